@@ rtl/core/uhid_pkg.sv @@
// Shared types, codes and descriptor tables of the HID mouse control responder.
`default_nettype none

package uhid_pkg;

    // Input item kinds carried on the slave-side tuser.
    localparam logic [1:0] OP_SETUP  = 2'd0;
    localparam logic [1:0] OP_IN     = 2'd1;
    localparam logic [1:0] OP_OUT    = 2'd2;
    localparam logic [1:0] OP_REPORT = 2'd3;

    // Result kinds carried on the master-side tuser.
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_ZLP  = 2'd1;
    localparam logic [1:0] KIND_DROP = 2'd2;

    // Request type groups (bmRequestType bits 6:5).
    localparam logic [1:0] RTYPE_STANDARD = 2'd0;
    localparam logic [1:0] RTYPE_CLASS    = 2'd1;

    // Request codes.
    localparam logic [7:0] REQ_SET_ADDRESS    = 8'h05;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
    localparam logic [7:0] REQ_SET_CONFIG     = 8'h09;
    localparam logic [7:0] REQ_GET_REPORT     = 8'h01;

    // Descriptor types.
    localparam logic [7:0] DESC_DEVICE = 8'h01;
    localparam logic [7:0] DESC_CONFIG = 8'h02;
    localparam logic [7:0] DESC_STRING = 8'h03;
    localparam logic [7:0] DESC_HID    = 8'h22;

    // Configuration register indexes.
    localparam logic REG_VENDOR_ID  = 1'b0;
    localparam logic REG_PRODUCT_ID = 1'b1;

    // Reset values of the identifiers.
    localparam logic [15:0] VENDOR_ID_RESET  = 16'h4348;
    localparam logic [15:0] PRODUCT_ID_RESET = 16'h55E2;

    // Stored lengths of the reply sources.
    localparam logic [6:0] LEN_DEV    = 7'd18;
    localparam logic [6:0] LEN_CFG    = 7'd34;
    localparam logic [6:0] LEN_HID    = 7'd52;
    localparam logic [6:0] LEN_STR0   = 7'd4;
    localparam logic [6:0] LEN_STR1   = 7'd14;
    localparam logic [6:0] LEN_STR2   = 7'd30;
    localparam logic [6:0] LEN_REPORT = 7'd4;

    // Source of the bytes of one reply.
    typedef enum logic [2:0] {
        SRC_DEV    = 3'd0,
        SRC_CFG    = 3'd1,
        SRC_HID    = 3'd2,
        SRC_STR0   = 3'd3,
        SRC_STR1   = 3'd4,
        SRC_STR2   = 3'd5,
        SRC_REPORT = 3'd6
    } uhid_src_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic emit;
    } uhid_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic final_result;
    } uhid_sts_t;

    // Fixed bytes of the device descriptor; the packet size and ids are patched in.
    localparam logic [7:0] DEV_ROM [18] = '{
        8'h12, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h01, 8'h02, 8'h00, 8'h01
    };

    // Configuration descriptor; the header declares 41 bytes but 34 are kept.
    // The endpoint packet size bytes are patched in.
    localparam logic [7:0] CFG_ROM [34] = '{
        8'h09, 8'h02, 8'h29, 8'h00, 8'h01, 8'h01, 8'h00, 8'hA0, 8'h32,
        8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01, 8'h02, 8'h00,
        8'h09, 8'h21, 8'h11, 8'h01, 8'h00, 8'h01, 8'h22, 8'h34, 8'h00,
        8'h07, 8'h05, 8'h81, 8'h03, 8'h00, 8'h00, 8'h01
    };

    // HID report descriptor.
    localparam logic [7:0] HID_ROM [52] = '{
        8'h05, 8'h01, 8'h09, 8'h02, 8'hA1, 8'h01, 8'h09, 8'h01, 8'hA1, 8'h00,
        8'h05, 8'h09, 8'h19, 8'h01, 8'h29, 8'h03, 8'h15, 8'h00, 8'h25, 8'h01,
        8'h95, 8'h03, 8'h75, 8'h01, 8'h81, 8'h02, 8'h95, 8'h01, 8'h75, 8'h05,
        8'h81, 8'h03, 8'h05, 8'h01, 8'h09, 8'h30, 8'h09, 8'h31, 8'h09, 8'h38,
        8'h15, 8'h81, 8'h25, 8'h7F, 8'h75, 8'h08, 8'h95, 8'h03, 8'h81, 8'h06,
        8'hC0, 8'hC0
    };

    // String descriptors: language list, manufacturer and product.
    localparam logic [7:0] STR0_ROM [4] = '{8'h04, 8'h03, 8'h09, 8'h04};

    localparam logic [7:0] STR1_ROM [14] = '{
        8'h0E, 8'h03, 8'h57, 8'h00, 8'h43, 8'h00, 8'h48, 8'h00,
        8'h20, 8'h00, 8'h43, 8'h00, 8'h6F, 8'h00
    };

    localparam logic [7:0] STR2_ROM [30] = '{
        8'h1E, 8'h03, 8'h43, 8'h00, 8'h48, 8'h00, 8'h33, 8'h00, 8'h32, 8'h00,
        8'h56, 8'h00, 8'h33, 8'h00, 8'h30, 8'h00, 8'h35, 8'h00, 8'h20, 8'h00,
        8'h48, 8'h00, 8'h49, 8'h00, 8'h44, 8'h00, 8'h20, 8'h00, 8'h4D, 8'h00
    };

endpackage

`default_nettype wire

@@ rtl/core/usb_hid_mouse_control_responder_core.sv @@
// Top level of the HID mouse control responder: ports, identifier registers and wiring.
//
//  Channel   Direction  Handshake            Content
//  s_*       in         s_tvalid / s_tready  one control item or mouse report
//  m_*       out        m_tvalid / m_tready  one result: a descriptor or report byte,
//                                            a zero-length handshake or a drop notice
//  APB       in         psel & penable       vendor_id at 0x0, product_id at 0x4
//
// An item is decoded when it is taken, then one result is loaded per cycle while the
// output register is empty or m_tready is high. A reply holds at most 52 bytes; a
// handshake or drop is one result. The pace is set by the single output register.
// Reset is asynchronous and needs no clearing pass; the block is ready right after it.
// A low m_tready holds the output register and the byte counter; the next item can be
// taken while the last result of the previous one still waits.
`default_nettype none

module usb_hid_mouse_control_responder_core #(
    parameter int MAX_PACKET = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [79:0] request_type, request_code, request_value, request_length,
    //        report_buttons, report_x, report_y, report_wheel
    input  logic [79:0] s_tdata,
    // [1:0] op
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] data_byte, byte_index, transfer_length, device_address, configured,
    //        three zero bits
    output logic [31:0] m_tdata,
    // [2:0] endpoint, kind
    output logic [2:0]  m_tuser,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import uhid_pkg::*;

    logic [15:0] vendor_id_reg;
    logic [15:0] product_id_reg;
    logic        cfg_write;
    uhid_cmd_t   cmd;
    uhid_sts_t   sts;

    // Configuration registers, written on the access cycle of a transfer.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vendor_id_reg  <= VENDOR_ID_RESET;
            product_id_reg <= PRODUCT_ID_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_VENDOR_ID)
            begin
                vendor_id_reg <= pwdata[15:0];
            end
            else
            begin
                product_id_reg <= pwdata[15:0];
            end
        end
    end

    // Register read-back.
    assign prdata = (paddr[2] == REG_PRODUCT_ID) ? {16'd0, product_id_reg}
                                                 : {16'd0, vendor_id_reg};

    uhid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    uhid_dp #(
        .MAX_PACKET (MAX_PACKET)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .vendor_id  (vendor_id_reg),
        .product_id (product_id_reg),
        .in_user    (s_tuser),
        .in_data    (s_tdata),
        .cmd        (cmd),
        .sts        (sts),
        .out_user   (m_tuser),
        .out_last   (m_tlast),
        .out_data   (m_tdata)
    );

endmodule

`default_nettype wire

@@ rtl/core/uhid_ctrl.sv @@
// Controller state machine: takes input items and paces results into the output register.
`default_nettype none

module uhid_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output uhid_pkg::uhid_cmd_t cmd,
    input  uhid_pkg::uhid_sts_t sts
);
    import uhid_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEND = 2'b10
    } uhid_state_t;

    uhid_state_t state_reg;
    uhid_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd.capture    = 1'b0;
        cmd.emit       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    if (sts.final_result)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    // A captured item always moves the controller into the send phase.
    a_capture_to_send: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == ST_SEND)
        else $error("capture did not start the send phase");

    // Loading the final result of an item returns to idle with a result pending.
    a_final_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && sts.final_result |=> state_reg == ST_IDLE && out_valid_reg)
        else $error("final result did not end the send phase");
`endif

endmodule

`default_nettype wire

@@ rtl/core/uhid_dp.sv @@
// Datapath: request decode, device state, descriptor byte lookup and output register.
`default_nettype none

module uhid_dp #(
    parameter int MAX_PACKET = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [15:0]         vendor_id,
    input  logic [15:0]         product_id,
    input  logic [1:0]          in_user,  // op
    // request_type, request_code, request_value, request_length,
    // report_buttons, report_x, report_y, report_wheel
    input  logic [79:0]         in_data,
    input  uhid_pkg::uhid_cmd_t cmd,
    output uhid_pkg::uhid_sts_t sts,
    // endpoint, kind
    output logic [2:0]          out_user,
    output logic                out_last,
    // data_byte, byte_index, transfer_length, device_address, configured, zero pad
    output logic [31:0]         out_data
);
    import uhid_pkg::*;

    localparam logic [15:0] MAXP16 = 16'(MAX_PACKET);
    localparam logic [6:0]  MAXP7  = 7'(MAX_PACKET);

    // Input fields.
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_length;
    logic [7:0]  report_buttons;
    logic [7:0]  report_x;
    logic [7:0]  report_y;
    logic [7:0]  report_wheel;

    assign request_type   = in_data[7:0];
    assign request_code   = in_data[15:8];
    assign request_value  = in_data[31:16];
    assign request_length = in_data[47:32];
    assign report_buttons = in_data[55:48];
    assign report_x       = in_data[63:56];
    assign report_y       = in_data[71:64];
    assign report_wheel   = in_data[79:72];

    // Device state.
    logic [6:0] address_reg;
    logic [6:0] address_next;
    logic       configured_reg;
    logic       configured_next;
    logic [7:0] buttons_reg;
    logic [7:0] x_reg;
    logic [7:0] y_reg;
    logic [7:0] wheel_reg;
    logic       store_report;

    // Reply plan of the current item.
    uhid_src_t  src_reg;
    uhid_src_t  src_next;
    logic [6:0] len_reg;
    logic [6:0] len_next;
    logic [1:0] kind_reg;
    logic [1:0] kind_next;
    logic       ep_reg;
    logic       ep_next;
    logic [5:0] idx_reg;

    // Output register.
    logic [2:0]  out_user_reg;
    logic        out_last_reg;
    logic [31:0] out_data_reg;

    // Descriptor lookup temporaries.
    logic       desc_found;
    logic [6:0] src_len;
    logic [6:0] cut_len;
    logic [7:0] rom_byte;
    logic [7:0] byte_field;
    logic [5:0] idx_field;
    logic [6:0] len_field;

    // Decode of the incoming item into a reply plan and state updates.
    always_comb
    begin
        address_next    = address_reg;
        configured_next = configured_reg;
        store_report    = 1'b0;
        src_next        = SRC_DEV;
        len_next        = 7'd0;
        kind_next       = KIND_ZLP;
        ep_next         = 1'b0;
        desc_found      = 1'b0;
        src_len         = 7'd0;
        cut_len         = 7'd0;

        // Descriptor source selection.
        case (request_value[15:8])
            DESC_DEVICE:
            begin
                desc_found = 1'b1;
                src_next   = SRC_DEV;
                src_len    = LEN_DEV;
            end
            DESC_CONFIG:
            begin
                desc_found = 1'b1;
                src_next   = SRC_CFG;
                src_len    = LEN_CFG;
            end
            DESC_HID:
            begin
                desc_found = 1'b1;
                src_next   = SRC_HID;
                src_len    = LEN_HID;
            end
            DESC_STRING:
            begin
                if (request_value[7:0] == 8'd0)
                begin
                    desc_found = 1'b1;
                    src_next   = SRC_STR0;
                    src_len    = LEN_STR0;
                end
                else if (request_value[7:0] == 8'd1)
                begin
                    desc_found = 1'b1;
                    src_next   = SRC_STR1;
                    src_len    = LEN_STR1;
                end
                else if (request_value[7:0] == 8'd2)
                begin
                    desc_found = 1'b1;
                    src_next   = SRC_STR2;
                    src_len    = LEN_STR2;
                end
            end
            default:
            begin
                desc_found = 1'b0;
            end
        endcase

        // Reply length is the smallest of stored, requested and packet size.
        cut_len = src_len;
        if (request_length < {9'd0, src_len})
        begin
            cut_len = request_length[6:0];
        end
        if (cut_len > MAXP7)
        begin
            cut_len = MAXP7;
        end

        if (in_user == OP_REPORT)
        begin
            ep_next = 1'b1;
            if (configured_reg)
            begin
                store_report = 1'b1;
                src_next     = SRC_REPORT;
                len_next     = LEN_REPORT;
                kind_next    = KIND_DATA;
            end
            else
            begin
                kind_next = KIND_DROP;
            end
        end
        else if (in_user == OP_SETUP)
        begin
            if (request_type[6:5] == RTYPE_STANDARD)
            begin
                if (request_code == REQ_SET_ADDRESS)
                begin
                    address_next = request_value[6:0];
                end
                else if (request_code == REQ_SET_CONFIG)
                begin
                    configured_next = 1'b1;
                end
                else if (request_code == REQ_GET_DESCRIPTOR)
                begin
                    if (desc_found && cut_len != 7'd0)
                    begin
                        len_next  = cut_len;
                        kind_next = KIND_DATA;
                    end
                end
            end
            else if (request_type[6:5] == RTYPE_CLASS && request_code == REQ_GET_REPORT)
            begin
                src_next  = SRC_REPORT;
                len_next  = LEN_REPORT;
                kind_next = KIND_DATA;
            end
        end
    end

    // Device state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_reg    <= 7'd0;
            configured_reg <= 1'b0;
            buttons_reg    <= 8'd0;
            x_reg          <= 8'd0;
            y_reg          <= 8'd0;
            wheel_reg      <= 8'd0;
        end
        else if (cmd.capture)
        begin
            address_reg    <= address_next;
            configured_reg <= configured_next;
            if (store_report)
            begin
                buttons_reg <= report_buttons;
                x_reg       <= report_x;
                y_reg       <= report_y;
                wheel_reg   <= report_wheel;
            end
        end
    end

    // Plan registers and byte counter.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            src_reg  <= src_next;
            len_reg  <= len_next;
            kind_reg <= kind_next;
            ep_reg   <= ep_next;
            idx_reg  <= 6'd0;
        end
        else if (cmd.emit)
        begin
            idx_reg <= idx_reg + 6'd1;
        end
    end

    // Byte at the current position of the selected source.
    always_comb
    begin
        case (src_reg)
            SRC_DEV:
            begin
                case (idx_reg)
                    6'd7:    rom_byte = MAXP16[7:0];
                    6'd8:    rom_byte = vendor_id[7:0];
                    6'd9:    rom_byte = vendor_id[15:8];
                    6'd10:   rom_byte = product_id[7:0];
                    6'd11:   rom_byte = product_id[15:8];
                    default: rom_byte = DEV_ROM[idx_reg[4:0]];
                endcase
            end
            SRC_CFG:
            begin
                case (idx_reg)
                    6'd31:   rom_byte = MAXP16[7:0];
                    6'd32:   rom_byte = MAXP16[15:8];
                    default: rom_byte = CFG_ROM[idx_reg];
                endcase
            end
            SRC_HID:  rom_byte = HID_ROM[idx_reg];
            SRC_STR0: rom_byte = STR0_ROM[idx_reg[1:0]];
            SRC_STR1: rom_byte = STR1_ROM[idx_reg[3:0]];
            SRC_STR2: rom_byte = STR2_ROM[idx_reg[4:0]];
            SRC_REPORT:
            begin
                case (idx_reg[1:0])
                    2'd0:    rom_byte = buttons_reg;
                    2'd1:    rom_byte = x_reg;
                    2'd2:    rom_byte = y_reg;
                    default: rom_byte = wheel_reg;
                endcase
            end
            default:  rom_byte = 8'd0;
        endcase
    end

    // Handshakes and dropped reports carry zero data, position and length.
    assign byte_field = (kind_reg == KIND_DATA) ? rom_byte : 8'd0;
    assign idx_field  = (kind_reg == KIND_DATA) ? idx_reg : 6'd0;
    assign len_field  = (kind_reg == KIND_DATA) ? len_reg : 7'd0;

    assign sts.final_result = (kind_reg != KIND_DATA) || ({1'b0, idx_reg} == len_reg - 7'd1);

    // Output register, loaded once per result.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_user_reg <= {kind_reg, ep_reg};
            out_last_reg <= sts.final_result;
            out_data_reg <= {3'd0, configured_reg, address_reg, len_field, idx_field,
                             byte_field};
        end
    end

    assign out_user = out_user_reg;
    assign out_last = out_last_reg;
    assign out_data = out_data_reg;

`ifndef SYNTHESIS
    // A data reply is never planned with zero bytes or more than a packet.
    a_plan_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> kind_reg != KIND_DATA || (len_reg != 7'd0 && len_reg <= MAXP7))
        else $error("data reply planned with a bad length");

    // The byte counter never runs past the reply length.
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && kind_reg == KIND_DATA |-> {1'b0, idx_reg} < len_reg)
        else $error("byte position ran past the reply length");
`endif

endmodule

`default_nettype wire

@@ tb/sv/usb_hid_mouse_control_responder_core_tb.sv @@
// Self-checking testbench of the HID mouse control responder core.
`timescale 1ns / 100ps

module usb_hid_mouse_control_responder_core_tb;

    import uhid_pkg::*;

    localparam int MAX_PKT      = 64;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int MAX_REPORTED = 10;

    // One control item or mouse report as it enters the block.
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  rtype;
        logic [7:0]  code;
        logic [15:0] value;
        logic [15:0] length;
        logic [7:0]  buttons;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  wheel;
    } usb_req_t;

    // One result as it leaves the block.
    typedef struct packed {
        logic        endpoint;
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [5:0]  byte_index;
        logic [6:0]  xfer_len;
        logic        last;
        logic [6:0]  dev_addr;
        logic        configured;
    } usb_result_t;

    // Scoreboard: tracks the device state and the queue of expected results.
    class hid_scoreboard;
        logic [15:0] vendor_id;
        logic [15:0] product_id;
        logic [6:0]  dev_addr;
        logic        configured;
        logic [7:0]  report_bytes [4];
        logic [7:0]  dev_desc [18];
        logic [7:0]  cfg_desc [34];
        logic [7:0]  hid_desc [52];
        logic [7:0]  str0_desc [4];
        logic [7:0]  str1_desc [14];
        logic [7:0]  str2_desc [30];
        usb_result_t expected_q [$];
        int          errors;
        int          requests;
        int          results;
        int          data_bytes;
        int          handshakes;
        int          drops;

        function new();
            vendor_id    = 16'h4348;
            product_id   = 16'h55E2;
            dev_addr     = '0;
            configured   = 1'b0;
            report_bytes = '{8'h00, 8'h00, 8'h00, 8'h00};
            errors       = 0;
            requests     = 0;
            results      = 0;
            data_bytes   = 0;
            handshakes   = 0;
            drops        = 0;
            // Packet size and identifiers are filled in when the reply is built.
            dev_desc = '{8'h12, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                         8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h01, 8'h02, 8'h00, 8'h01};
            cfg_desc = '{8'h09, 8'h02, 8'h29, 8'h00, 8'h01, 8'h01, 8'h00, 8'hA0, 8'h32,
                         8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01, 8'h02, 8'h00,
                         8'h09, 8'h21, 8'h11, 8'h01, 8'h00, 8'h01, 8'h22, 8'h34, 8'h00,
                         8'h07, 8'h05, 8'h81, 8'h03, 8'h00, 8'h00, 8'h01};
            hid_desc = '{8'h05, 8'h01, 8'h09, 8'h02, 8'hA1, 8'h01, 8'h09, 8'h01, 8'hA1,
                         8'h00, 8'h05, 8'h09, 8'h19, 8'h01, 8'h29, 8'h03, 8'h15, 8'h00,
                         8'h25, 8'h01, 8'h95, 8'h03, 8'h75, 8'h01, 8'h81, 8'h02, 8'h95,
                         8'h01, 8'h75, 8'h05, 8'h81, 8'h03, 8'h05, 8'h01, 8'h09, 8'h30,
                         8'h09, 8'h31, 8'h09, 8'h38, 8'h15, 8'h81, 8'h25, 8'h7F, 8'h75,
                         8'h08, 8'h95, 8'h03, 8'h81, 8'h06, 8'hC0, 8'hC0};
            str0_desc = '{8'h04, 8'h03, 8'h09, 8'h04};
            str1_desc = '{8'h0E, 8'h03, 8'h57, 8'h00, 8'h43, 8'h00, 8'h48, 8'h00,
                          8'h20, 8'h00, 8'h43, 8'h00, 8'h6F, 8'h00};
            str2_desc = '{8'h1E, 8'h03, 8'h43, 8'h00, 8'h48, 8'h00, 8'h33, 8'h00, 8'h32,
                          8'h00, 8'h56, 8'h00, 8'h33, 8'h00, 8'h30, 8'h00, 8'h35, 8'h00,
                          8'h20, 8'h00, 8'h48, 8'h00, 8'h49, 8'h00, 8'h44, 8'h00, 8'h20,
                          8'h00, 8'h4D, 8'h00};
        endfunction

        function void set_register(logic idx, logic [15:0] val);
            if (idx == REG_VENDOR_ID)
                vendor_id = val;
            else
                product_id = val;
        endfunction

        function void fail(string msg);
            errors++;
            if (errors <= MAX_REPORTED)
                $display("ERROR: %s", msg);
        endfunction

        function void check_register(logic idx, logic [15:0] got);
            logic [15:0] want;
            want = (idx == REG_VENDOR_ID) ? vendor_id : product_id;
            if (got !== want)
                fail($sformatf("register %0d read %04h, expected %04h", idx, got, want));
        endfunction

        function string show(usb_result_t r);
            return $sformatf("ep=%0d kind=%0d data=%02h idx=%0d len=%0d last=%0d addr=%0d cfg=%0d",
                             r.endpoint, r.kind, r.data_byte, r.byte_index, r.xfer_len,
                             r.last, r.dev_addr, r.configured);
        endfunction

        function void push_result(logic ep, logic [1:0] kind, logic [7:0] data, int idx,
                                  int len, logic last);
            usb_result_t r;
            r.endpoint   = ep;
            r.kind       = kind;
            r.data_byte  = data;
            r.byte_index = idx[5:0];
            r.xfer_len   = len[6:0];
            r.last       = last;
            r.dev_addr   = dev_addr;
            r.configured = configured;
            expected_q.push_back(r);
        endfunction

        // Work out every result that one accepted item causes.
        function void predict_request(usb_req_t r);
            logic [7:0] reply [64];
            int         n;
            logic       ep;
            logic       stream;
            n      = 0;
            ep     = 1'b0;
            stream = 1'b0;
            requests++;
            if (r.op == OP_REPORT)
            begin
                // Reports are dropped until the host has configured the device.
                if (!configured)
                begin
                    drops++;
                    push_result(1'b1, KIND_DROP, 8'h00, 0, 0, 1'b1);
                    return;
                end
                report_bytes = '{r.buttons, r.x, r.y, r.wheel};
                ep     = 1'b1;
                stream = 1'b1;
                n      = 4;
                for (int i = 0; i < 4; i++)
                    reply[i] = report_bytes[i];
            end
            else if (r.op == OP_SETUP && r.rtype[6:5] == RTYPE_STANDARD)
            begin
                case (r.code)
                    REQ_SET_ADDRESS: dev_addr = r.value[6:0];
                    REQ_SET_CONFIG:  configured = 1'b1;
                    REQ_GET_DESCRIPTOR:
                    begin
                        stream = 1'b1;
                        case (r.value[15:8])
                            DESC_DEVICE:
                            begin
                                n = 18;
                                for (int i = 0; i < 18; i++)
                                    reply[i] = dev_desc[i];
                                reply[7]  = MAX_PKT[7:0];
                                reply[8]  = vendor_id[7:0];
                                reply[9]  = vendor_id[15:8];
                                reply[10] = product_id[7:0];
                                reply[11] = product_id[15:8];
                            end
                            DESC_CONFIG:
                            begin
                                n = 34;
                                for (int i = 0; i < 34; i++)
                                    reply[i] = cfg_desc[i];
                                reply[31] = MAX_PKT[7:0];
                                reply[32] = MAX_PKT[15:8];
                            end
                            DESC_HID:
                            begin
                                n = 52;
                                for (int i = 0; i < 52; i++)
                                    reply[i] = hid_desc[i];
                            end
                            DESC_STRING:
                            begin
                                // String length is whatever its first byte states.
                                case (r.value[7:0])
                                    8'd0:
                                    begin
                                        n = int'(str0_desc[0]);
                                        for (int i = 0; i < 4; i++)
                                            reply[i] = str0_desc[i];
                                    end
                                    8'd1:
                                    begin
                                        n = int'(str1_desc[0]);
                                        for (int i = 0; i < 14; i++)
                                            reply[i] = str1_desc[i];
                                    end
                                    8'd2:
                                    begin
                                        n = int'(str2_desc[0]);
                                        for (int i = 0; i < 30; i++)
                                            reply[i] = str2_desc[i];
                                    end
                                    default: stream = 1'b0;
                                endcase
                            end
                            default: stream = 1'b0;
                        endcase
                        if (int'(r.length) < n)
                            n = int'(r.length);
                        if (n > MAX_PKT)
                            n = MAX_PKT;
                    end
                    default: ;
                endcase
            end
            else if (r.op == OP_SETUP && r.rtype[6:5] == RTYPE_CLASS &&
                     r.code == REQ_GET_REPORT)
            begin
                stream = 1'b1;
                n      = 4;
                for (int i = 0; i < 4; i++)
                    reply[i] = report_bytes[i];
            end
            // Anything without bytes to send gets a zero-length handshake.
            if (!stream || n == 0)
            begin
                handshakes++;
                push_result(1'b0, KIND_ZLP, 8'h00, 0, 0, 1'b1);
            end
            else
            begin
                data_bytes += n;
                for (int i = 0; i < n; i++)
                    push_result(ep, KIND_DATA, reply[i], i, n, i == n - 1);
            end
        endfunction

        // Compare one output transfer with the oldest expectation.
        function void check_result(usb_result_t got);
            usb_result_t want;
            string       bad;
            results++;
            if (expected_q.size() == 0)
            begin
                fail($sformatf("result with nothing expected: %s", show(got)));
                return;
            end
            want = expected_q.pop_front();
            bad  = "";
            if (got.endpoint !== want.endpoint)     bad = {bad, " endpoint"};
            if (got.kind !== want.kind)             bad = {bad, " kind"};
            if (got.data_byte !== want.data_byte)   bad = {bad, " data_byte"};
            if (got.byte_index !== want.byte_index) bad = {bad, " byte_index"};
            if (got.xfer_len !== want.xfer_len)     bad = {bad, " transfer_length"};
            if (got.last !== want.last)             bad = {bad, " last"};
            if (got.dev_addr !== want.dev_addr)     bad = {bad, " device_address"};
            if (got.configured !== want.configured) bad = {bad, " configured"};
            if (bad != "")
                fail($sformatf("result %0d wrong in%s\n  expected %s\n  actual   %s",
                               results, bad, show(want), show(got)));
        endfunction

        function void check_leftover();
            if (expected_q.size() != 0)
                fail($sformatf("%0d expected results never arrived, first: %s",
                               expected_q.size(), show(expected_q[0])));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          tx_idle_pct = 8;
    int          rx_idle_pct = 53;
    logic        hold_start = 1'b0;
    logic        hold_taken = 1'b0;
    int          hold_left = 0;
    int          stall_cycles = 0;
    usb_result_t seen;

    hid_scoreboard sb = new();

    usb_hid_mouse_control_responder_core #(
        .MAX_PACKET(MAX_PKT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // Output side: random back-pressure, plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_start && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Unpack each accepted output transfer and check it.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.data_byte  = m_tdata[7:0];
            seen.byte_index = m_tdata[13:8];
            seen.xfer_len   = m_tdata[20:14];
            seen.dev_addr   = m_tdata[27:21];
            seen.configured = m_tdata[28];
            seen.endpoint   = m_tuser[0];
            seen.kind       = m_tuser[2:1];
            seen.last       = m_tlast;
            sb.check_result(seen);
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", stall_cycles);
                $display("tb: failure");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Random filler for every field of an item.
    function automatic usb_req_t rand_bits();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(usb_req_t)-1:0];
    endfunction

    function automatic usb_req_t setup_req(logic [7:0] rtype, logic [7:0] code,
                                           logic [15:0] value, logic [15:0] length);
        usb_req_t r;
        r        = rand_bits();
        r.op     = OP_SETUP;
        r.rtype  = rtype;
        r.code   = code;
        r.value  = value;
        r.length = length;
        return r;
    endfunction

    function automatic usb_req_t report_req(logic [7:0] buttons, logic [7:0] x,
                                            logic [7:0] y, logic [7:0] wheel);
        usb_req_t r;
        r         = rand_bits();
        r.op      = OP_REPORT;
        r.buttons = buttons;
        r.x       = x;
        r.y       = y;
        r.wheel   = wheel;
        return r;
    endfunction

    function automatic usb_req_t token_req(logic [1:0] op);
        usb_req_t r;
        r    = rand_bits();
        r.op = op;
        return r;
    endfunction

    // Mostly well-formed requests with random content, some plain noise.
    function automatic usb_req_t rand_request();
        usb_req_t r;
        int       pick;
        r    = rand_bits();
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            r.op         = OP_SETUP;
            r.rtype[6:5] = RTYPE_STANDARD;
            r.code       = REQ_GET_DESCRIPTOR;
            case ($urandom_range(0, 4))
                0: r.value[15:8] = DESC_DEVICE;
                1: r.value[15:8] = DESC_CONFIG;
                2: r.value[15:8] = DESC_STRING;
                3: r.value[15:8] = DESC_HID;
                default: ;
            endcase
            if ($urandom_range(0, 3) != 0)
                r.value[7:0] = 8'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0, 1: r.length = 16'($urandom_range(0, 64));
                2: r.length = 16'hFFFF;
                default: ;
            endcase
        end
        else if (pick < 45)
        begin
            r.op         = OP_SETUP;
            r.rtype[6:5] = RTYPE_STANDARD;
            r.code       = REQ_SET_ADDRESS;
        end
        else if (pick < 50)
        begin
            r.op         = OP_SETUP;
            r.rtype[6:5] = RTYPE_STANDARD;
            r.code       = REQ_SET_CONFIG;
        end
        else if (pick < 60)
        begin
            r.op         = OP_SETUP;
            r.rtype[6:5] = RTYPE_CLASS;
            r.code       = REQ_GET_REPORT;
        end
        else if (pick < 82)
        begin
            r.op = OP_REPORT;
        end
        else if (pick < 90)
        begin
            r.op = ($urandom_range(0, 1) != 0) ? OP_IN : OP_OUT;
        end
        return r;
    endfunction

    // Offer one item, with a random gap first, and note it once accepted.
    task automatic send_item(input usb_req_t r);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {r.wheel, r.y, r.x, r.buttons, r.length, r.value, r.code, r.rtype};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.predict_request(r);
    endtask

    // Stop offering and wait until every expected result has arrived.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random(input int count, input int drain_at, input int hold_at);
        for (int i = 0; i < count; i++)
        begin
            if (i == drain_at)
                wait_drain();
            if (i == hold_at)
                hold_start <= 1'b1;
            send_item(rand_request());
        end
    endtask

    // APB transfers run back to back; apb_idle closes a sequence of them.
    task automatic apb_write(input logic idx, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_register(idx, val);
    endtask

    task automatic apb_read(input logic idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.check_register(idx, prdata[15:0]);
    endtask

    task automatic apb_idle();
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_read(REG_VENDOR_ID);
        apb_read(REG_PRODUCT_ID);
        apb_idle();

        // Directed part: reports before configuration, every descriptor, odd requests.
        send_item(report_req(8'h80, 8'h7F, 8'h81, 8'h00));
        send_item(token_req(OP_IN));
        send_item(token_req(OP_OUT));
        send_item(setup_req(8'hA1, REQ_GET_REPORT, 16'h0000, 16'h0004));
        send_item(setup_req(8'h80, REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'h00}, 16'hFFFF));
        send_item(setup_req(8'h80, REQ_GET_DESCRIPTOR, {DESC_CONFIG, 8'h00}, 16'hFFFF));
        send_item(setup_req(8'h80, REQ_GET_DESCRIPTOR, {DESC_CONFIG, 8'h00}, 16'h0009));
        send_item(setup_req(8'h81, REQ_GET_DESCRIPTOR, {DESC_HID, 8'h00}, 16'h0100));
        send_item(setup_req(8'h80, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'h00}, 16'h00FF));
        send_item(setup_req(8'h80, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'h01}, 16'h00FF));
        send_item(setup_req(8'h80, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'h02}, 16'h00FF));
        send_item(setup_req(8'h80, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'h03}, 16'h00FF));
        send_item(setup_req(8'h80, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'h01}, 16'h0002));
        send_item(setup_req(8'h80, REQ_GET_DESCRIPTOR, 16'h0400, 16'h00FF));
        send_item(setup_req(8'h80, REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'h00}, 16'h0000));
        send_item(setup_req(8'h00, REQ_SET_ADDRESS, 16'hFFFF, 16'h0000));
        send_item(setup_req(8'h00, REQ_SET_ADDRESS, 16'h002A, 16'h0000));
        send_item(setup_req(8'h40, REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'h00}, 16'h0040));
        send_item(setup_req(8'h60, REQ_GET_REPORT, 16'h0000, 16'h0004));
        send_item(setup_req(8'h21, REQ_SET_CONFIG, 16'h0001, 16'h0000));
        send_item(setup_req(8'h00, 8'h00, 16'h0000, 16'h0002));
        send_item(setup_req(8'h00, REQ_SET_CONFIG, 16'h0001, 16'h0000));
        send_item(report_req(8'hFF, 8'h7F, 8'h80, 8'hFF));
        send_item(report_req(8'h00, 8'h80, 8'h7F, 8'h01));
        send_item(setup_req(8'hA1, REQ_GET_REPORT, 16'h0100, 16'hFFFF));

        // Sender idles rarely, receiver often.
        run_random(150, -1, -1);
        wait_drain();
        apb_write(REG_VENDOR_ID, 16'h0000);
        apb_write(REG_PRODUCT_ID, 16'hFFFF);
        apb_read(REG_VENDOR_ID);
        apb_read(REG_PRODUCT_ID);
        apb_idle();

        // Sender idles often, receiver rarely; one full drain in the middle.
        tx_idle_pct = 53;
        rx_idle_pct = 8;
        run_random(150, 75, -1);
        wait_drain();
        apb_write(REG_VENDOR_ID, 16'hFFFF);
        apb_write(REG_PRODUCT_ID, 16'h0000);
        apb_read(REG_VENDOR_ID);
        apb_read(REG_PRODUCT_ID);
        apb_idle();

        // No idling on either side; a long output hold-off fills the block.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(150, -1, 40);
        wait_drain();
        apb_write(REG_VENDOR_ID, 16'($urandom));
        apb_write(REG_PRODUCT_ID, 16'($urandom));
        apb_read(REG_VENDOR_ID);
        apb_read(REG_PRODUCT_ID);
        apb_idle();
        send_item(setup_req(8'h80, REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'h00}, 16'h0012));
        run_random(10, -1, -1);
        wait_drain();

        repeat (60) @(posedge clk);
        sb.check_leftover();
        $display("summary: %0d items, %0d results (%0d data bytes, %0d handshakes, %0d drops)",
                 sb.requests, sb.results, sb.data_bytes, sb.handshakes, sb.drops);
        $display("summary: three rounds of id writes, three idle mixes, one long output hold-off");
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/uhid_pkg.sv
rtl/core/uhid_ctrl.sv
rtl/core/uhid_dp.sv
rtl/core/usb_hid_mouse_control_responder_core.sv
tb/sv/usb_hid_mouse_control_responder_core_tb.sv
